@@ rtl/rlmd_pkg.sv @@
package rlmd_pkg;

    // Default sizing
    localparam int MAX_COLS_DEF  = 4096;
    localparam int ELEV_BITS_DEF = 32;

    // Fixed field and register widths
    localparam int COLS_CFG_W = 13;
    localparam int ROWS_CFG_W = 16;
    localparam int ROW_CNT_W  = 17;
    localparam int PIX_COL_W  = 12;
    localparam int PIX_ROW_W  = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 4'd1;

    localparam logic [COLS_CFG_W-1:0] IMAGE_COLS_RST = 13'd4096;
    localparam logic [ROWS_CFG_W-1:0] IMAGE_ROWS_RST = 16'd1;

    // Per-item decision control, worked out from the stream position
    typedef struct packed {
        logic decide;     // a pixel decision is delivered
        logic done;       // decided pixel is the last of the frame
        logic left_ok;    // west neighbors lie inside the image
        logic right_ok;   // east neighbors lie inside the image
        logic top_ok;     // north neighbors lie inside the image
        logic bot_ok;     // south neighbors lie inside the image
    } rlmd_ctrl_t;

endpackage

@@ rtl/rlmd_line_buffer.sv @@
module rlmd_line_buffer #(
    parameter int MAX_COLS  = rlmd_pkg::MAX_COLS_DEF,
    parameter int ELEV_BITS = rlmd_pkg::ELEV_BITS_DEF,
    localparam int CNT_W    = $clog2(MAX_COLS),
    localparam int CELL_W   = ELEV_BITS + 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [CNT_W-1:0]  rd_addr,
    input  logic              wr_en,
    input  logic [CELL_W-1:0] wr_cell,
    output logic [CELL_W-1:0] col_top,
    output logic [CELL_W-1:0] col_mid
);

    // Each entry holds {upper row, middle row} for one column.
    logic [2*CELL_W-1:0] mem [MAX_COLS];
    logic [2*CELL_W-1:0] mem_q_reg;
    logic [2*CELL_W-1:0] byp_data_reg;
    logic                byp_reg;
    logic [CNT_W-1:0]    addr_reg;
    logic [2*CELL_W-1:0] rd_data;
    logic [2*CELL_W-1:0] wr_data;

    assign rd_data = byp_reg ? byp_data_reg : mem_q_reg;
    assign col_top = rd_data[2*CELL_W-1:CELL_W];
    assign col_mid = rd_data[CELL_W-1:0];
    // Shift the column up: middle becomes upper, new pixel becomes middle.
    assign wr_data = {col_mid, wr_cell};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr_reg] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg    <= mem[rd_addr];
            byp_data_reg <= wr_data;
            addr_reg     <= rd_addr;
        end
    end

    // Forward a write that lands on the address read at the same edge.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else if (rd_en) begin
            byp_reg <= wr_en && (rd_addr == addr_reg);
        end
    end

endmodule

@@ rtl/rlmd_window_eval.sv @@
module rlmd_window_eval #(
    parameter int ELEV_BITS = rlmd_pkg::ELEV_BITS_DEF,
    localparam int CELL_W   = ELEV_BITS + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 shift_en,
    input  rlmd_pkg::rlmd_ctrl_t ctrl,
    input  logic [CELL_W-1:0]    east_top,
    input  logic [CELL_W-1:0]    east_mid,
    input  logic [CELL_W-1:0]    east_bot,
    output logic                 is_minimum,
    output logic [CELL_W-1:0]    centre_cell
);

    logic [CELL_W-1:0] west_reg   [3];
    logic [CELL_W-1:0] centre_reg [3];
    logic [CELL_W-1:0] nb   [8];
    logic [7:0]        nb_en;
    logic [7:0]        lower;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 3; j++) begin
                west_reg[j]   <= '0;
                centre_reg[j] <= '0;
            end
        end else if (shift_en) begin
            west_reg      <= centre_reg;
            centre_reg[0] <= east_top;
            centre_reg[1] <= east_mid;
            centre_reg[2] <= east_bot;
        end
    end

    // Neighbors of the centre pixel, with the incoming column as the east side.
    always_comb begin
        nb[0] = west_reg[0];    nb_en[0] = ctrl.left_ok & ctrl.top_ok;
        nb[1] = west_reg[1];    nb_en[1] = ctrl.left_ok;
        nb[2] = west_reg[2];    nb_en[2] = ctrl.left_ok & ctrl.bot_ok;
        nb[3] = centre_reg[0];  nb_en[3] = ctrl.top_ok;
        nb[4] = centre_reg[2];  nb_en[4] = ctrl.bot_ok;
        nb[5] = east_top;       nb_en[5] = ctrl.right_ok & ctrl.top_ok;
        nb[6] = east_mid;       nb_en[6] = ctrl.right_ok;
        nb[7] = east_bot;       nb_en[7] = ctrl.right_ok & ctrl.bot_ok;
        for (int i = 0; i < 8; i++) begin
            lower[i] = nb_en[i] && !nb[i][CELL_W-1]
                    && ($signed(nb[i][ELEV_BITS-1:0])
                        < $signed(centre_reg[1][ELEV_BITS-1:0]));
        end
    end

    // Ties do not disqualify: plateau cells count as minima.
    assign is_minimum  = !centre_reg[1][CELL_W-1] && (lower == '0);
    assign centre_cell = centre_reg[1];

endmodule

@@ rtl/raster_local_minimum_detect_core.sv @@
// 3x3 local-minimum detector for an elevation raster streamed in raster order.
//
// Input channel (s_*): one pixel per transaction, elevation plus a nodata
// flag. After the last pixel of a frame, send image_cols + 1 padding
// transactions (s_is_padding high) to flush the final decisions.
// Result channel (m_*): exactly one transaction per input transaction. It
// carries the decision for the pixel one row and one column behind the input;
// when m_decision_valid is low every field is zero. m_frame_done marks the
// last pixel of the frame, after which the position counters restart.
// Config channel (cfg_*): index 0 writes image_cols, index 1 image_rows;
// other indexes are dropped. Write only while the pipeline is empty.
// Throughput: one transaction per clock while the receiver does not stall, set
// by the line store, which takes one read and one write per cycle. An accepted
// transaction is registered in stage 1, then in the output register.
// Reset: counters and window clear, image_cols = 4096, image_rows = 1; the
// line store keeps whatever it holds and is rewritten by the first rows.
// Receiver stall: the output register holds; one more transaction is taken
// into the stage 1 register, then s_ready drops until m_ready returns.
module raster_local_minimum_detect_core #(
    parameter int MAX_COLS  = rlmd_pkg::MAX_COLS_DEF,
    parameter int ELEV_BITS = rlmd_pkg::ELEV_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rlmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rlmd_pkg::CFG_DATA_W-1:0]     cfg_data,
    // pixel stream in
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [ELEV_BITS-1:0]         s_elevation,
    input  logic                                s_is_nodata,
    input  logic                                s_is_padding,
    // decisions out
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_decision_valid,
    output logic                                m_is_minimum,
    output logic [rlmd_pkg::PIX_COL_W-1:0]      m_pixel_col,
    output logic [rlmd_pkg::PIX_ROW_W-1:0]      m_pixel_row,
    output logic signed [ELEV_BITS-1:0]         m_pixel_elevation,
    output logic                                m_frame_done
);

    localparam int CNT_W  = $clog2(MAX_COLS);
    localparam int CW     = $clog2(MAX_COLS + 1);
    localparam int CELL_W = ELEV_BITS + 1;
    localparam int RCW    = rlmd_pkg::ROW_CNT_W;

    // configuration registers
    logic [rlmd_pkg::COLS_CFG_W-1:0] image_cols_reg;
    logic [rlmd_pkg::ROWS_CFG_W-1:0] image_rows_reg;

    // stream position of the next input pixel
    logic [CNT_W-1:0] col_cnt_reg, col_cnt_next;
    logic [RCW-1:0]   row_cnt_reg, row_cnt_next;

    // stage 0 (accept) decode
    logic [CW-1:0]        cols_eff;
    logic [RCW-1:0]       rows_eff;
    logic [CW-1:0]        c_ext, c_inc, dc;
    logic [RCW-1:0]       dr;
    logic                 have, wrap, s0_overrun;
    rlmd_pkg::rlmd_ctrl_t s0_ctrl;
    logic [CELL_W-1:0]    s0_cell;
    logic                 accept;

    // stage 1 (line store read, window shift, decision)
    logic                            p1_valid_reg;
    rlmd_pkg::rlmd_ctrl_t            p1_ctrl_reg;
    logic [rlmd_pkg::PIX_COL_W-1:0]  p1_col_reg;
    logic [rlmd_pkg::PIX_ROW_W-1:0]  p1_row_reg;
    logic [CELL_W-1:0]               p1_cell_reg;
    logic [CELL_W-1:0]               col_top, col_mid, centre_cell;
    logic                            win_minimum;
    logic                            out_load, move1;

    // output register
    logic                            m_valid_reg;
    logic                            m_decision_valid_reg;
    logic                            m_is_minimum_reg;
    logic [rlmd_pkg::PIX_COL_W-1:0]  m_pixel_col_reg;
    logic [rlmd_pkg::PIX_ROW_W-1:0]  m_pixel_row_reg;
    logic [ELEV_BITS-1:0]            m_pixel_elevation_reg;
    logic                            m_frame_done_reg;

    // ---------------------------------------------------------------
    // Configuration: always ready, unknown indexes are dropped.
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_cols_reg <= rlmd_pkg::IMAGE_COLS_RST;
            image_rows_reg <= rlmd_pkg::IMAGE_ROWS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rlmd_pkg::REG_IMAGE_COLS:
                    image_cols_reg <= cfg_data[rlmd_pkg::COLS_CFG_W-1:0];
                rlmd_pkg::REG_IMAGE_ROWS:
                    image_rows_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: the output register frees stage 1, stage 1 frees input.
    // ---------------------------------------------------------------
    assign out_load = !m_valid_reg || m_ready;
    assign move1    = p1_valid_reg && out_load;
    assign s_ready  = !p1_valid_reg || out_load;
    assign accept   = s_valid && s_ready;

    // ---------------------------------------------------------------
    // Stage 0: clamp the frame size, locate the decided pixel.
    // ---------------------------------------------------------------
    always_comb begin
        // zero columns act as one; oversize clamps to the line store depth
        if (image_cols_reg == '0) begin
            cols_eff = CW'(1);
        end else if (32'(image_cols_reg) > 32'(MAX_COLS)) begin
            cols_eff = CW'(MAX_COLS);
        end else begin
            cols_eff = CW'(image_cols_reg);
        end
        rows_eff = (image_rows_reg == '0) ? RCW'(1) : RCW'(image_rows_reg);

        c_ext = CW'(col_cnt_reg);
        c_inc = c_ext + CW'(1);
        wrap  = (c_inc >= cols_eff);

        // Decided pixel trails the input by one row and one column.
        if (col_cnt_reg != '0) begin
            have = (row_cnt_reg != '0);
            dc   = c_ext - CW'(1);
            dr   = row_cnt_reg - RCW'(1);
        end else begin
            have = (row_cnt_reg >= RCW'(2));
            dc   = cols_eff - CW'(1);
            dr   = row_cnt_reg - RCW'(2);
        end

        // Past the last row: no decision, restart the frame.
        s0_overrun       = have && (dr >= rows_eff);
        s0_ctrl.decide   = have && !s0_overrun && (dc < cols_eff);
        s0_ctrl.done     = s0_ctrl.decide && (dc == cols_eff - CW'(1))
                           && (dr == rows_eff - RCW'(1));
        s0_ctrl.left_ok  = (dc != '0);
        s0_ctrl.right_ok = ((dc + CW'(1)) < cols_eff);
        s0_ctrl.top_ok   = (dr != '0);
        s0_ctrl.bot_ok   = ((dr + RCW'(1)) < rows_eff);

        if (s0_overrun || s0_ctrl.done) begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end else if (wrap) begin
            col_cnt_next = '0;
            row_cnt_next = row_cnt_reg + RCW'(1);
        end else begin
            col_cnt_next = c_inc[CNT_W-1:0];
            row_cnt_next = row_cnt_reg;
        end

        // Padding and nodata pixels enter the window as nodata, elevation zero.
        s0_cell[CELL_W-1]    = s_is_nodata || s_is_padding;
        s0_cell[ELEV_BITS-1:0] = s0_cell[CELL_W-1] ? '0 : s_elevation;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (accept) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1 register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (move1) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_ctrl_reg <= s0_ctrl;
            p1_col_reg  <= s0_ctrl.decide ? rlmd_pkg::PIX_COL_W'(dc) : '0;
            p1_row_reg  <= s0_ctrl.decide ? dr[rlmd_pkg::PIX_ROW_W-1:0] : '0;
            p1_cell_reg <= s0_cell;
        end
    end

    rlmd_line_buffer #(
        .MAX_COLS  (MAX_COLS),
        .ELEV_BITS (ELEV_BITS)
    ) u_line_buffer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (col_cnt_reg),
        .wr_en   (move1),
        .wr_cell (p1_cell_reg),
        .col_top (col_top),
        .col_mid (col_mid)
    );

    rlmd_window_eval #(
        .ELEV_BITS (ELEV_BITS)
    ) u_window_eval (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .shift_en    (move1),
        .ctrl        (p1_ctrl_reg),
        .east_top    (col_top),
        .east_mid    (col_mid),
        .east_bot    (p1_cell_reg),
        .is_minimum  (win_minimum),
        .centre_cell (centre_cell)
    );

    // ---------------------------------------------------------------
    // Output register: load on stage 1 advance, hold while stalled.
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (move1) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move1) begin
            m_decision_valid_reg  <= p1_ctrl_reg.decide;
            m_is_minimum_reg      <= p1_ctrl_reg.decide && win_minimum;
            m_pixel_col_reg       <= p1_col_reg;
            m_pixel_row_reg       <= p1_row_reg;
            m_pixel_elevation_reg <= p1_ctrl_reg.decide ? centre_cell[ELEV_BITS-1:0] : '0;
            m_frame_done_reg      <= p1_ctrl_reg.done;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_decision_valid  = m_decision_valid_reg;
    assign m_is_minimum      = m_is_minimum_reg;
    assign m_pixel_col       = m_pixel_col_reg;
    assign m_pixel_row       = m_pixel_row_reg;
    assign m_pixel_elevation = m_pixel_elevation_reg;
    assign m_frame_done      = m_frame_done_reg;

`ifndef ASSERT_OFF
    // Frame end or overrun restarts the position counters.
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s0_ctrl.done || s0_overrun)
        |=> (col_cnt_reg == '0) && (row_cnt_reg == '0))
        else $error("position counters not cleared after frame end");

    // Input is refused only when both stages are full and the output stalls.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> p1_valid_reg && m_valid_reg && !m_ready)
        else $error("input refused with room in the pipeline");

    // A stalled stage 1 keeps its transaction.
    a_p1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && !out_load
        |=> p1_valid_reg && $stable(p1_col_reg) && $stable(p1_row_reg))
        else $error("stage 1 lost its transaction under stall");

    // A result without a decision carries zero fields.
    a_no_decision_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_decision_valid
        |-> !m_is_minimum && !m_frame_done && (m_pixel_elevation == '0)
            && (m_pixel_col == '0) && (m_pixel_row == '0))
        else $error("nonzero fields on a result without decision");
`endif

endmodule
